@@ design/hlc_pkg.sv @@
// hlc_pkg: shared types, widths and constants for the homogeneous line clipper
// depends on nothing
package hlc_pkg;
   localparam int unsigned CoordWidth = 32;
   localparam int unsigned EdgeWidth  = 34;
   localparam int unsigned TWidth     = 17;
   localparam int unsigned TFrac      = 16;
   localparam int unsigned DivSteps   = TFrac + 1;
   localparam int unsigned NumPlanes  = 6;
   localparam logic [TWidth-1:0] TOne = 17'h10000;

   typedef logic signed [CoordWidth-1:0] coord_type;
   typedef logic signed [EdgeWidth-1:0]  edge_type;
   typedef logic [TWidth-1:0]            t_type;

   // one endpoint pair plus outcodes, carried down the pipeline
   typedef struct packed {
      coord_type [3:0] p0;
      coord_type [3:0] p1;
      logic [NumPlanes-1:0] c0;
      logic [NumPlanes-1:0] c1;
   } seg_type;

   // one plane's division in flight
   typedef struct packed {
      logic             act;
      logic             entry;
      logic [EdgeWidth:0] rem;
      logic [EdgeWidth-1:0] den;
      t_type            q;
   } div_type;
endpackage

@@ design/hlc_div_cell.sv @@
// hlc_div_cell: one restoring division step for all six planes
// depends on hlc_pkg
module hlc_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  valid_in,
   input  hlc_pkg::seg_type      seg_in,
   input  hlc_pkg::div_type [5:0] div_in,
   output logic                  valid_out,
   output hlc_pkg::seg_type      seg_out,
   output hlc_pkg::div_type [5:0] div_out
);
   import hlc_pkg::*;

   logic    valid_ff;
   seg_type seg_ff;
   div_type [5:0] div_ff, div_in_c;
   logic [EdgeWidth:0] diff;

   always_comb begin
      div_in_c = div_in;
      for (int j = 0; j < NumPlanes; j++) begin
         diff = div_in[j].rem - {1'b0, div_in[j].den};
         if (!diff[EdgeWidth]) begin
            div_in_c[j].rem = {diff[EdgeWidth-1:0], 1'b0};
            div_in_c[j].q   = {div_in[j].q[TWidth-2:0], 1'b1};
         end else begin
            div_in_c[j].rem = {div_in[j].rem[EdgeWidth-1:0], 1'b0};
            div_in_c[j].q   = {div_in[j].q[TWidth-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      seg_ff   <= seg_in;
      div_ff   <= div_in_c;
   end

   assign valid_out = valid_ff;
   assign seg_out   = seg_ff;
   assign div_out   = div_ff;
endmodule

@@ design/hlc_interp_lane.sv @@
// hlc_interp_lane: interpolates one coordinate at t1 and t2, two stages
// depends on hlc_pkg
module hlc_interp_lane (
   input  logic              clock,
   input  hlc_pkg::coord_type s,
   input  hlc_pkg::coord_type e,
   input  hlc_pkg::t_type    t1,
   input  hlc_pkg::t_type    t2,
   output hlc_pkg::coord_type n0,
   output hlc_pkg::coord_type n1
);
   import hlc_pkg::*;

   logic signed [CoordWidth:0] d;
   logic [CoordWidth:0] mag;
   logic [CoordWidth+TWidth:0] pa_ff, pb_ff;
   logic neg_ff;
   coord_type s_ff;
   logic [CoordWidth:0] qa, qb;

   assign d   = {e[CoordWidth-1], e} - {s[CoordWidth-1], s};
   assign mag = d[CoordWidth] ? (~d + 1'b1) : d;

   always_ff @(posedge clock) begin
      pa_ff  <= mag * t1;
      pb_ff  <= mag * t2;
      neg_ff <= d[CoordWidth];
      s_ff   <= s;
   end

   assign qa = pa_ff[CoordWidth+TFrac:TFrac];
   assign qb = pb_ff[CoordWidth+TFrac:TFrac];
   assign n0 = neg_ff ? s_ff - qa[CoordWidth-1:0] : s_ff + qa[CoordWidth-1:0];
   assign n1 = neg_ff ? s_ff - qb[CoordWidth-1:0] : s_ff + qb[CoordWidth-1:0];
endmodule

@@ design/homogeneous_line_clipper_unit.sv @@
// homogeneous_line_clipper_unit: liang-barsky clipping in homogeneous space
// one segment a cycle, busy stays low
// edge stage, 17 division cells (one quotient bit each), min/max stage,
// multiply stage, add stage; results cannot be stalled by the receiver
// synchronous active-high reset clears only the valid bits of the pipeline
module homogeneous_line_clipper_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic signed [31:0]         req_start_x,
   input  logic signed [31:0]         req_start_y,
   input  logic signed [31:0]         req_start_z,
   input  logic signed [31:0]         req_start_w,
   input  logic signed [31:0]         req_end_x,
   input  logic signed [31:0]         req_end_y,
   input  logic signed [31:0]         req_end_z,
   input  logic signed [31:0]         req_end_w,
   output logic                       rsp_valid,
   output logic                       rsp_visible,
   output logic signed [31:0]         rsp_clipped_start_x,
   output logic signed [31:0]         rsp_clipped_start_y,
   output logic signed [31:0]         rsp_clipped_start_z,
   output logic signed [31:0]         rsp_clipped_start_w,
   output logic signed [31:0]         rsp_clipped_end_x,
   output logic signed [31:0]         rsp_clipped_end_y,
   output logic signed [31:0]         rsp_clipped_end_z,
   output logic signed [31:0]         rsp_clipped_end_w,
   output logic                       rsp_end_unclipped,
   output logic [5:0]                 rsp_start_outcode,
   output logic [5:0]                 rsp_end_outcode
);
   import hlc_pkg::*;

   // never stalls: one beat in per cycle
   assign busy = 1'b0;

   // ---- stage 0: edge values, outcodes, divider set-up ----
   logic    v0_ff;
   seg_type seg0_ff;
   div_type [5:0] div0_ff;
   seg_type seg_c;
   div_type [5:0] div_c;
   edge_type e0 [6];
   edge_type e1 [6];
   edge_type num, den;

   always_comb begin
      seg_c.p0 = {req_start_w, req_start_z, req_start_y, req_start_x};
      seg_c.p1 = {req_end_w, req_end_z, req_end_y, req_end_x};
      for (int k = 0; k < 3; k++) begin
         e0[2*k]   = EdgeWidth'(req_start_w) + EdgeWidth'(seg_c.p0[k]);
         e0[2*k+1] = EdgeWidth'(req_start_w) - EdgeWidth'(seg_c.p0[k]);
         e1[2*k]   = EdgeWidth'(req_end_w) + EdgeWidth'(seg_c.p1[k]);
         e1[2*k+1] = EdgeWidth'(req_end_w) - EdgeWidth'(seg_c.p1[k]);
      end
      for (int j = 0; j < NumPlanes; j++) begin
         seg_c.c0[j] = e0[j][EdgeWidth-1];
         seg_c.c1[j] = e1[j][EdgeWidth-1];
         num = e0[j][EdgeWidth-1] ? -e0[j] : e0[j];
         den = e0[j][EdgeWidth-1] ? (e1[j] - e0[j]) : (e0[j] - e1[j]);
         // plane counts only when at least one end is outside and the divisor is positive
         div_c[j].act   = (seg_c.c0[j] | seg_c.c1[j]) && !den[EdgeWidth-1] && den != '0;
         div_c[j].entry = seg_c.c0[j];
         div_c[j].rem   = {1'b0, num};
         div_c[j].den   = den;
         div_c[j].q     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start & ~busy;
      end
      seg0_ff <= seg_c;
      div0_ff <= div_c;
   end

   // ---- chain of division cells, one quotient bit per cell ----
   logic    vc [DivSteps+1];
   seg_type sc [DivSteps+1];
   div_type [5:0] dc [DivSteps+1];

   assign vc[0] = v0_ff;
   assign sc[0] = seg0_ff;
   assign dc[0] = div0_ff;

   for (genvar g = 0; g < DivSteps; g++) begin : g_cell
      hlc_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .valid_in (vc[g]),
         .seg_in   (sc[g]),
         .div_in   (dc[g]),
         .valid_out(vc[g+1]),
         .seg_out  (sc[g+1]),
         .div_out  (dc[g+1])
      );
   end

   // ---- t1/t2 narrowing ----
   logic    v1_ff;
   seg_type seg1_ff;
   t_type   t1_ff, t2_ff, t1_c, t2_c, tq;
   logic    vis_ff, vis_c;

   always_comb begin
      t1_c = '0;
      t2_c = TOne;
      for (int j = 0; j < NumPlanes; j++) begin
         tq = (dc[DivSteps][j].q > TOne) ? TOne : dc[DivSteps][j].q;
         if (dc[DivSteps][j].act) begin
            if (dc[DivSteps][j].entry) begin
               if (tq > t1_c) t1_c = tq;
            end else if (tq < t2_c) begin
               t2_c = tq;
            end
         end
      end
      vis_c = ((sc[DivSteps].c0 & sc[DivSteps].c1) == '0) && (t2_c >= t1_c);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= vc[DivSteps];
      end
      seg1_ff <= sc[DivSteps];
      t1_ff   <= t1_c;
      t2_ff   <= t2_c;
      vis_ff  <= vis_c;
   end

   // ---- interpolation lanes (multiply then add) ----
   coord_type n0 [4];
   coord_type n1 [4];
   for (genvar g = 0; g < 4; g++) begin : g_lane
      hlc_interp_lane u_lane (
         .clock(clock),
         .s    (seg1_ff.p0[g]),
         .e    (seg1_ff.p1[g]),
         .t1   (t1_ff),
         .t2   (t2_ff),
         .n0   (n0[g]),
         .n1   (n1[g])
      );
   end

   logic    v2_ff, vis2_ff, eu2_ff, k0_ff, k1_ff;
   seg_type seg2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      seg2_ff <= seg1_ff;
      vis2_ff <= vis_ff;
      eu2_ff  <= vis_ff && t2_ff == TOne;
      k0_ff   <= !vis_ff || t1_ff == '0;
      k1_ff   <= !vis_ff || t2_ff == TOne;
   end

   // ---- output register ----
   logic      rv_ff, rvis_ff, reu_ff;
   coord_type [3:0] rs_ff, re_ff;
   logic [5:0] rc0_ff, rc1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= v2_ff;
      end
      rvis_ff <= vis2_ff;
      reu_ff  <= eu2_ff;
      rc0_ff  <= seg2_ff.c0;
      rc1_ff  <= seg2_ff.c1;
      for (int k = 0; k < 4; k++) begin
         rs_ff[k] <= k0_ff ? seg2_ff.p0[k] : n0[k];
         re_ff[k] <= k1_ff ? seg2_ff.p1[k] : n1[k];
      end
   end

   assign rsp_valid           = rv_ff;
   assign rsp_visible         = rvis_ff;
   assign rsp_end_unclipped   = reu_ff;
   assign rsp_start_outcode   = rc0_ff;
   assign rsp_end_outcode     = rc1_ff;
   assign rsp_clipped_start_x = rs_ff[0];
   assign rsp_clipped_start_y = rs_ff[1];
   assign rsp_clipped_start_z = rs_ff[2];
   assign rsp_clipped_start_w = rs_ff[3];
   assign rsp_clipped_end_x   = re_ff[0];
   assign rsp_clipped_end_y   = re_ff[1];
   assign rsp_clipped_end_z   = re_ff[2];
   assign rsp_clipped_end_w   = re_ff[3];

`ifndef SYNTHESIS
   // an unclipped end implies a visible segment
   a_eu_vis: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_unclipped |-> rsp_visible) else $error("end_unclipped without visible");
   // shared outcode bit means reject
   a_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_start_outcode & rsp_end_outcode) != 6'd0 |-> !rsp_visible)
      else $error("trivial reject missed");
   // entry never beyond exit on a visible segment
   a_span: assert property (@(posedge clock) disable iff (reset)
      v1_ff && vis_ff |-> t2_ff >= t1_ff) else $error("empty span marked visible");
`endif
endmodule

@@ bench/homogeneous_line_clipper_checker.sv @@
// homogeneous_line_clipper_checker: watches request and result beats of the clipper,
// predicts each clipped segment and compares field by field; depends on hlc_pkg
`timescale 1ns / 1ps
module homogeneous_line_clipper_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  hlc_pkg::coord_type  req_start_x, req_start_y, req_start_z, req_start_w,
   input  hlc_pkg::coord_type  req_end_x, req_end_y, req_end_z, req_end_w,
   input  logic                rsp_valid,
   input  logic                rsp_visible,
   input  hlc_pkg::coord_type  rsp_clipped_start_x, rsp_clipped_start_y,
   input  hlc_pkg::coord_type  rsp_clipped_start_z, rsp_clipped_start_w,
   input  hlc_pkg::coord_type  rsp_clipped_end_x, rsp_clipped_end_y,
   input  hlc_pkg::coord_type  rsp_clipped_end_z, rsp_clipped_end_w,
   input  logic                rsp_end_unclipped,
   input  logic [5:0]          rsp_start_outcode,
   input  logic [5:0]          rsp_end_outcode,
   output int                  fail_count,
   output int                  pending_count,
   output logic                beat_seen
);
   import hlc_pkg::*;

   typedef struct packed {
      logic            vis;
      coord_type [3:0] s;
      coord_type [3:0] e;
      logic            unclipped;
      logic [5:0]      sc;
      logic [5:0]      ec;
   } clip_type;

   clip_type clip_q[$];

   function automatic longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   function automatic longint lerp(longint s, longint d, longint unsigned t);
      longint unsigned q;
      q = (magnitude(d) * t) >> 16;
      return (d < 0) ? s - longint'(q) : s + longint'(q);
   endfunction

   function automatic clip_type clip_segment(coord_type [3:0] a, coord_type [3:0] b);
      clip_type r;
      longint pa[4], pb[4], ea[6], eb[6];
      longint num, den, d;
      longint unsigned t, t1, t2;
      t1 = 0;
      t2 = 65536;
      for (int i = 0; i < 4; i++) begin
         pa[i] = a[i];
         pb[i] = b[i];
      end
      for (int k = 0; k < 3; k++) begin
         ea[2*k] = pa[3] + pa[k];  ea[2*k+1] = pa[3] - pa[k];
         eb[2*k] = pb[3] + pb[k];  eb[2*k+1] = pb[3] - pb[k];
      end
      r.sc = '0;
      r.ec = '0;
      for (int j = 0; j < 6; j++) begin
         r.sc[j] = ea[j] < 0;
         r.ec[j] = eb[j] < 0;
      end
      r.vis = 1'b0;
      r.unclipped = 1'b0;
      r.s = a;
      r.e = b;
      if ((r.sc & r.ec) == 0) begin
         for (int j = 0; j < 6; j++) begin
            if (ea[j] < 0 || eb[j] < 0) begin
               num = (ea[j] < 0) ? -ea[j] : ea[j];
               den = (ea[j] < 0) ? eb[j] - ea[j] : ea[j] - eb[j];
               if (den > 0) begin
                  t = (longint'(num) << 16) / longint'(den);
                  if (t > 65536) t = 65536;
                  if (ea[j] < 0) begin
                     if (t > t1) t1 = t;
                  end else if (t < t2) begin
                     t2 = t;
                  end
               end
            end
         end
         if (t2 >= t1) begin
            r.vis = 1'b1;
            r.unclipped = (t2 == 65536);
            for (int i = 0; i < 4; i++) begin
               d = pb[i] - pa[i];
               if (t2 != 65536) r.e[i] = coord_type'(lerp(pa[i], d, t2));
               if (t1 != 0) r.s[i] = coord_type'(lerp(pa[i], d, t1));
            end
         end
      end
      return r;
   endfunction

   task automatic compare_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $display("%0t mismatch %s expected %0d actual %0d", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   initial fail_count = 0;
   assign pending_count = clip_q.size();
   assign beat_seen = (start && !busy) || rsp_valid;

   always @(posedge clock) begin
      clip_type x, g;
      if (!reset) begin
         if (rsp_valid) begin
            g.vis = rsp_visible;
            g.s = {rsp_clipped_start_w, rsp_clipped_start_z,
                   rsp_clipped_start_y, rsp_clipped_start_x};
            g.e = {rsp_clipped_end_w, rsp_clipped_end_z, rsp_clipped_end_y, rsp_clipped_end_x};
            g.unclipped = rsp_end_unclipped;
            g.sc = rsp_start_outcode;
            g.ec = rsp_end_outcode;
            if (clip_q.size() == 0) begin
               $display("%0t unexpected result beat visible %0d", $time, rsp_visible);
               fail_count++;
            end else begin
               x = clip_q.pop_front();
               compare_field("visible", x.vis, g.vis);
               for (int i = 0; i < 4; i++) begin
                  compare_field($sformatf("start[%0d]", i), x.s[i], g.s[i]);
                  compare_field($sformatf("end[%0d]", i), x.e[i], g.e[i]);
               end
               compare_field("end_unclipped", x.unclipped, g.unclipped);
               compare_field("start_outcode", x.sc, g.sc);
               compare_field("end_outcode", x.ec, g.ec);
            end
         end
         if (start && !busy)
            clip_q.push_back(clip_segment(
               {req_start_w, req_start_z, req_start_y, req_start_x},
               {req_end_w, req_end_z, req_end_y, req_end_x}));
      end
   end
endmodule

@@ bench/homogeneous_line_clipper_unit_tb.sv @@
// homogeneous_line_clipper_unit_tb: stimulus, clock, reset and verdict for the clipper
// depends on hlc_pkg, homogeneous_line_clipper_unit and homogeneous_line_clipper_checker
`timescale 1ns / 1ps
module homogeneous_line_clipper_unit_tb;
   import hlc_pkg::*;

   localparam int Latency = 21;
   localparam int WatchdogLimit = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   coord_type sx = '0, sy = '0, sz = '0, sw = '0, ex = '0, ey = '0, ez = '0, ew = '0;
   logic rsp_valid, rsp_visible, rsp_end_unclipped;
   coord_type csx, csy, csz, csw, cex, cey, cez, cew;
   logic [5:0] rsp_start_outcode, rsp_end_outcode;
   int fail_count, pending_count;
   logic beat_seen;
   int idle_cycles = 0;

   always #2 clock = ~clock;

   homogeneous_line_clipper_unit u_top (
      .clock, .reset, .start, .busy,
      .req_start_x(sx), .req_start_y(sy), .req_start_z(sz), .req_start_w(sw),
      .req_end_x(ex), .req_end_y(ey), .req_end_z(ez), .req_end_w(ew),
      .rsp_valid, .rsp_visible,
      .rsp_clipped_start_x(csx), .rsp_clipped_start_y(csy),
      .rsp_clipped_start_z(csz), .rsp_clipped_start_w(csw),
      .rsp_clipped_end_x(cex), .rsp_clipped_end_y(cey),
      .rsp_clipped_end_z(cez), .rsp_clipped_end_w(cew),
      .rsp_end_unclipped, .rsp_start_outcode, .rsp_end_outcode
   );

   homogeneous_line_clipper_checker u_checker (
      .clock, .reset, .start, .busy,
      .req_start_x(sx), .req_start_y(sy), .req_start_z(sz), .req_start_w(sw),
      .req_end_x(ex), .req_end_y(ey), .req_end_z(ez), .req_end_w(ew),
      .rsp_valid, .rsp_visible,
      .rsp_clipped_start_x(csx), .rsp_clipped_start_y(csy),
      .rsp_clipped_start_z(csz), .rsp_clipped_start_w(csw),
      .rsp_clipped_end_x(cex), .rsp_clipped_end_y(cey),
      .rsp_clipped_end_z(cez), .rsp_clipped_end_w(cew),
      .rsp_end_unclipped, .rsp_start_outcode, .rsp_end_outcode,
      .fail_count, .pending_count, .beat_seen
   );

   // watchdog: counts cycles with no beat in either direction
   always @(posedge clock) begin
      if (beat_seen || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("FAIL homogeneous_line_clipper_unit");
         $finish;
      end
   end

   // random coordinate: mostly moderate, sometimes near full scale
   function automatic coord_type rand_coord(int scale);
      case ($urandom_range(0, 9))
         0: return coord_type'($urandom());
         1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         default: return coord_type'(int'($urandom_range(0, 2*scale)) - scale);
      endcase
   endfunction

   // one beat: hold start until accepted, start left high for back-to-back beats
   task automatic send_segment(coord_type a0, a1, a2, a3, b0, b1, b2, b3);
      sx <= a0; sy <= a1; sz <= a2; sw <= a3;
      ex <= b0; ey <= b1; ez <= b2; ew <= b3;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic gap(int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   localparam coord_type Pmax = 32'sh7fffffff;
   localparam coord_type Nmax = 32'sh80000000;
   localparam coord_type One  = 32'sh00010000;

   initial begin
      int burst;
      coord_type w0, w1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: inside, trivial reject, clip at both ends, empty span, extremes
      send_segment(0, 0, 0, One, One/2, -One/2, One/4, One);
      send_segment(2*One, 0, 0, One, 3*One, One/2, 0, One);
      send_segment(-2*One, 0, 0, One, 2*One, 0, 0, One);
      send_segment(0, 0, 0, One, 4*One, 0, 0, One);
      send_segment(-3*One, 0, 0, One, 0, 0, 0, One);
      send_segment(-2*One, One/2, 0, One, One/2, 2*One, 0, One);
      send_segment(-2*One, 0, 3*One, One, 0, -2*One, -3*One, One);
      send_segment(Pmax, Pmax, Pmax, Pmax, Nmax, Nmax, Nmax, Nmax);
      send_segment(Nmax, Nmax, Nmax, Nmax, Pmax, Pmax, Pmax, Pmax);
      send_segment(Pmax, Nmax, Pmax, Nmax, Nmax, Pmax, Nmax, Pmax);
      send_segment(0, 0, 0, 0, 0, 0, 0, 0);
      send_segment(-1, -1, -1, -1, -1, -1, -1, -1);
      send_segment(0, 0, 0, Pmax, Nmax, 0, 0, 0);
      send_segment(0, 0, Pmax, 0, 0, Nmax, 0, Pmax);
      send_segment(One, 0, 0, One, -One, 0, 0, One);
      send_segment(0, 2*One, 0, One, 0, 0, -2*One, One);
      gap(3);
      // pause until everything has drained
      wait_drained();

      for (int n = 0; n < 650; ) begin
         burst = $urandom_range(1, 40);
         for (int k = 0; k < burst && n < 650; k++, n++) begin
            w0 = coord_type'($urandom_range(1, 8*65536));
            w1 = coord_type'($urandom_range(1, 8*65536));
            if ($urandom_range(0, 7) == 0) begin
               send_segment(rand_coord(1 << 30), rand_coord(1 << 30), rand_coord(1 << 30),
                            rand_coord(1 << 30), rand_coord(1 << 30), rand_coord(1 << 30),
                            rand_coord(1 << 30), rand_coord(1 << 30));
            end else begin
               send_segment(rand_coord(3*w0), rand_coord(3*w0), rand_coord(3*w0), w0,
                            rand_coord(3*w1), rand_coord(3*w1), rand_coord(3*w1), w1);
            end
         end
         if (n == 325) wait_drained();
         else if ($urandom_range(0, 2) != 0) gap($urandom_range(1, 30));
      end
      wait_drained();
      repeat (Latency + 5) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS homogeneous_line_clipper_unit");
      end else begin
         $display("FAIL homogeneous_line_clipper_unit");
      end
      $finish;
   end
endmodule

@@ homogeneous_line_clipper_unit.f @@
design/hlc_pkg.sv
design/hlc_div_cell.sv
design/hlc_interp_lane.sv
design/homogeneous_line_clipper_unit.sv
bench/homogeneous_line_clipper_checker.sv
bench/homogeneous_line_clipper_unit_tb.sv
